// ----- design/tcw_pkg.sv -----
// Package for the text console writer: item types and request codes.
`timescale 1ns / 1ps

package tcw_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Character codes with a meaning of their own
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  // Input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic       at_position;
    logic [6:0] column;
    logic [4:0] line;
  } tcw_in_t;

  // Result item
  typedef struct packed {
    logic [10:0] cursor_cell;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } tcw_out_t;

endpackage

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: cursor, sequencer and cell store.
`timescale 1ns / 1ps

// The console keeps COLUMNS x ROWS character/attribute cells (character in the
// low byte) in one single-port-write RAM, plus a cursor held as row and column.
// Each request gives exactly one result. A put without scroll passes through
// S_PUT and a read through S_RADDR, both then through S_POS; an ignored request
// (bad position or unused type) goes straight to S_POS. A clear and a put that
// scrolls walk the whole store with one address counter, one cell a cycle
// through the RAM ports, then pass S_DRAIN and S_POS; a put that scrolls does
// its own write first. After reset the same walk zeroes the store: in_ready
// stays low until it is done. The input is not ready while a request is in
// work; a finished result waits in the output register.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tcw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tcw_out_t out_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int EW    = AW + 11;

  localparam logic [AW-1:0]  COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0]  MOVE_A   = AW'(COLUMNS * (ROWS - 1));
  localparam logic [AW-1:0]  LAST_A   = AW'(CELLS - 1);
  localparam logic [8:0]     COL_LIM  = 9'(COLUMNS);
  localparam logic [7:0]     ROW_LIM  = 8'(ROWS);
  localparam logic [CLW-1:0] COL_LAST = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [RW:0]    ROW_END  = (RW + 1)'(ROWS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_RADDR,
    S_SWEEP,
    S_DRAIN,
    S_POS
  } state_t;

  typedef enum logic [1:0] {
    SW_ZERO,
    SW_FILL,
    SW_COPY
  } sweep_mode_t;

  state_t      state_r, state_nxt;
  sweep_mode_t mode_r, mode_nxt;
  logic        out_valid_r, out_valid_nxt;
  tcw_out_t    out_data_r, out_data_nxt;
  tcw_in_t     req_r, req_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CLW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0]  tgt_row_r, tgt_row_nxt;
  logic [CLW-1:0] tgt_col_r, tgt_col_nxt;
  logic        scrolled_r, scrolled_nxt;
  logic        rd_hit_r, rd_hit_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic        sw_valid_r, sw_valid_nxt;
  logic [AW-1:0] sw_addr_r, sw_addr_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic [AW-1:0] tgt_addr;
  logic [AW-1:0] cur_addr;
  logic [EW-1:0] cur_ext;
  logic [15:0]   sweep_data;
  logic          is_newline;
  logic          pos_ok;
  logic [RW:0]   next_row;
  logic [CLW-1:0] next_col;

  // Cell addresses of the target and of the cursor
  assign tgt_addr   = AW'(tgt_row_r) * COLS_A + AW'(tgt_col_r);
  assign cur_addr   = AW'(cur_row_r) * COLS_A + AW'(cur_col_r);
  assign cur_ext    = EW'(cur_addr);
  assign is_newline = (req_r.char_code == NEWLINE_CODE);

  // Explicit positions outside the screen are dropped
  assign pos_ok = !in_data.at_position ||
                  (({2'b00, in_data.column} < COL_LIM) &&
                   ({3'b000, in_data.line} < ROW_LIM));

  // Position after a put: newline or last column wraps to the next row
  always_comb begin
    if (is_newline || (tgt_col_r == COL_LAST)) begin
      next_row = {1'b0, tgt_row_r} + 1'b1;
      next_col = '0;
    end else begin
      next_row = {1'b0, tgt_row_r};
      next_col = tgt_col_r + 1'b1;
    end
  end

  // Data written by the sweep: moved row, blank or zero
  always_comb begin
    if ((sw_addr_r < MOVE_A) && (mode_r == SW_COPY)) begin
      sweep_data = ram_rdata;
    end else if ((sw_addr_r < MOVE_A) && (mode_r == SW_FILL)) begin
      sweep_data = {req_r.attribute, SPACE_CODE};
    end else begin
      sweep_data = '0;
    end
  end

  // RAM ports: the lagged sweep write or the put write; sweep read or cell read
  assign ram_we    = sw_valid_r || ((state_r == S_PUT) && !is_newline);
  assign ram_waddr = sw_valid_r ? sw_addr_r : tgt_addr;
  assign ram_wdata = sw_valid_r ? sweep_data : {req_r.attribute, req_r.char_code};
  assign ram_re    = ((state_r == S_SWEEP) && (cnt_r < MOVE_A)) || (state_r == S_RADDR);
  assign ram_raddr = (state_r == S_SWEEP) ? (cnt_r + COLS_A) : tgt_addr;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req_nxt       = req_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    tgt_row_nxt   = tgt_row_r;
    tgt_col_nxt   = tgt_col_r;
    scrolled_nxt  = scrolled_r;
    rd_hit_nxt    = rd_hit_r;
    cnt_nxt       = cnt_r;
    sw_valid_nxt  = 1'b0;
    sw_addr_nxt   = sw_addr_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          scrolled_nxt = 1'b0;
          rd_hit_nxt   = 1'b0;
          if (in_data.at_position) begin
            tgt_row_nxt = RW'(in_data.line);
            tgt_col_nxt = CLW'(in_data.column);
          end else begin
            tgt_row_nxt = cur_row_r;
            tgt_col_nxt = cur_col_r;
          end
          case (in_data.req_type)
            REQ_PUT: begin
              state_nxt = pos_ok ? S_PUT : S_POS;
            end
            REQ_CLEAR: begin
              mode_nxt     = SW_FILL;
              cnt_nxt      = '0;
              cur_row_nxt  = '0;
              cur_col_nxt  = '0;
              scrolled_nxt = 1'b1;
              state_nxt    = S_SWEEP;
            end
            REQ_READ: begin
              state_nxt = pos_ok ? S_RADDR : S_POS;
            end
            default: begin
              state_nxt = S_POS;
            end
          endcase
        end
      end
      S_PUT: begin
        // Advance the cursor; scroll when it runs off the last row
        if (next_row == ROW_END) begin
          cur_row_nxt  = ROW_LAST;
          cur_col_nxt  = '0;
          scrolled_nxt = 1'b1;
          mode_nxt     = SW_COPY;
          cnt_nxt      = '0;
          state_nxt    = S_SWEEP;
        end else begin
          cur_row_nxt = next_row[RW-1:0];
          cur_col_nxt = next_col;
          state_nxt   = S_POS;
        end
      end
      S_RADDR: begin
        rd_hit_nxt = 1'b1;
        state_nxt  = S_POS;
      end
      S_SWEEP: begin
        // Walk every cell; each write comes in the cycle after its read
        sw_valid_nxt = 1'b1;
        sw_addr_nxt  = cnt_r;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_A) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = (mode_r == SW_ZERO) ? S_IDLE : S_POS;
      end
      S_POS: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.cursor_cell = cur_ext[10:0];
          out_data_nxt.scrolled    = scrolled_r;
          out_data_nxt.cell_char   = rd_hit_r ? ram_rdata[7:0] : 8'd0;
          out_data_nxt.cell_attr   = rd_hit_r ? ram_rdata[15:8] : 8'd0;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the zeroing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      mode_r      <= SW_ZERO;
      out_valid_r <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cnt_r       <= '0;
      sw_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      cnt_r       <= cnt_nxt;
      sw_valid_r  <= sw_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    scrolled_r <= scrolled_nxt;
    rd_hit_r   <= rd_hit_nxt;
    sw_addr_r  <= sw_addr_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
